// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked check, held off during reset
`define SLRG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
   else $error("slrg check failed");

// antecedent in this cycle, consequent in the next
`define SLRG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("slrg sequence check failed");

`endif

// ===== sv/slrg_pkg.sv =====
package slrg_pkg;

   // step count width and the counter widths that follow from it
   localparam int STEP_BITS = 16;
   localparam int COUNT_W   = STEP_BITS + 1;
   localparam int WIDE_W    = STEP_BITS + 2;
   localparam int DATA_W    = 16;

   // shared divider operand widths
   localparam int DVD_W     = COUNT_W + DATA_W;
   localparam int DVS_W     = (WIDE_W + 2 > DATA_W + 1) ? WIDE_W + 2 : DATA_W + 1;
   localparam int DIV_CNT_W = $clog2(DVD_W);

   // alarm value reported on a start that moves
   localparam logic [DATA_W-1:0] ALARM_START = DATA_W'(100);

   // operation codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DELAY   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_RATE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DECEL_RATE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DELAY     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_FLOOR   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_CEILING = 3'd6;

   // ramp phase
   typedef enum logic [1:0] {
      PH_STOP  = 2'd0,
      PH_ACCEL = 2'd1,
      PH_RUN   = 2'd2,
      PH_DECEL = 2'd3
   } phase_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_SPLIT,
      ST_DIV_SPLIT,
      ST_WAIT_SPLIT,
      ST_MUL_DECEL,
      ST_DIV_DECEL,
      ST_WAIT_DECEL,
      ST_TICK_DIV,
      ST_TICK_WAIT,
      ST_COMMIT
   } seq_state_type;

   // input transaction
   typedef struct packed {
      logic                        operation;
      logic signed [STEP_BITS-1:0] move_steps;
      logic                        pin_level;
   } req_type;

   // result transaction
   typedef struct packed {
      logic              step_level;
      logic              step_drive;
      logic              direction;
      logic              running;
      logic [DATA_W-1:0] alarm_delay;
      logic              timer_enabled;
   } rsp_type;

   // divider command and result
   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== sv/slrg_divider.sv =====
module slrg_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  slrg_pkg::div_req_type div_req,
   output slrg_pkg::div_rsp_type div_rsp
);

   localparam int DVD_W     = slrg_pkg::DVD_W;
   localparam int DVS_W     = slrg_pkg::DVS_W;
   localparam int DIV_CNT_W = slrg_pkg::DIV_CNT_W;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;

   logic [DVS_W:0] trial;
   logic [DVS_W:0] diff;
   logic           fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         // a zero divisor gives a zero quotient at once
         if (div_req.divisor == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quo_in  = '0;
            rem_in  = '0;
         end else begin
            busy_in = 1'b1;
            cnt_in  = '0;
            quo_in  = div_req.dividend;
            rem_in  = '0;
            dvs_in  = div_req.divisor;
         end
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== sv/stepper_linear_ramp_generator_unit.sv =====
// Trapezoidal stepper ramp generator with linear acceleration. A start transaction
// (operation 0) sets direction, doubles the step count and splits the move into
// acceleration and deceleration parts; a tick transaction (operation 1) drives the
// step pin, advances the ACCEL/RUN/DECEL/STOP ramp and returns the next alarm delay,
// clamped to the floor and ceiling registers. Every transaction gives one result.
// One transaction is worked at a time and req_ready is high only while the block
// waits for work. Ticks in RUN or STOP and a zero-step start go from idle straight to
// the commit state; ticks in ACCEL or DECEL and a start that moves wait on the
// bit-serial divider, which a speed-limited start runs again for the deceleration
// length. The divider is shared by the ramp split, the speed-limited deceleration
// length and the (4n+1) delay update. A finished result waits in the output register
// while the next transaction is taken in; that transaction's commit then waits as
// long as the earlier result is not taken. Configuration writes are always accepted.
`include "assert_macros.svh"

module stepper_linear_ramp_generator_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  slrg_pkg::req_type                      req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output slrg_pkg::rsp_type                      rsp_payload,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [slrg_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [slrg_pkg::DATA_W-1:0]            csr_data
);

   localparam int STEP_BITS = slrg_pkg::STEP_BITS;
   localparam int COUNT_W   = slrg_pkg::COUNT_W;
   localparam int WIDE_W    = slrg_pkg::WIDE_W;
   localparam int DATA_W    = slrg_pkg::DATA_W;
   localparam int DVD_W     = slrg_pkg::DVD_W;
   localparam int DVS_W     = slrg_pkg::DVS_W;

   // configuration registers
   logic [DATA_W-1:0] first_delay_ff, max_speed_ff, accel_rate_ff, decel_rate_ff;
   logic [DATA_W-1:0] min_delay_ff, delay_floor_ff, delay_ceiling_ff;

   // sequencer and working registers
   slrg_pkg::seq_state_type state_ff, state_in;
   slrg_pkg::req_type       req_ff, req_in;
   logic [COUNT_W-1:0]      n_ff, n_in;
   logic [COUNT_W-1:0]      dlen_ff, dlen_in;
   logic [DVD_W-1:0]        prod_ff, prod_in;
   logic [DVD_W-1:0]        q_ff, q_in;
   logic [DVS_W-1:0]        r_ff, r_in;
   logic [WIDE_W-1:0]       ri_work_ff, ri_work_in;

   // ramp state
   slrg_pkg::phase_type phase_ff, phase_in;
   logic [COUNT_W-1:0]  steps_done_ff, steps_done_in;
   logic [WIDE_W-1:0]   ramp_index_ff, ramp_index_in;
   logic [WIDE_W-1:0]   rem_ff, rem_in;
   logic [DATA_W-1:0]   cur_ff, cur_in;
   logic [DATA_W-1:0]   pending_ff, pending_in;
   logic [DATA_W-1:0]   ramp_end_ff, ramp_end_in;
   logic [WIDE_W-1:0]   decel_length_ff, decel_length_in;
   logic [WIDE_W-1:0]   decel_begin_ff, decel_begin_in;
   logic                dir_ff, dir_in;
   logic                run_ff, run_in;
   logic                timer_on_ff, timer_on_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   slrg_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   // divider link
   slrg_pkg::div_req_type div_req;
   slrg_pkg::div_rsp_type div_rsp;

   // shared multiplier operands
   logic [COUNT_W-1:0] mul_a;
   logic [DATA_W-1:0]  mul_b;
   logic [DVD_W-1:0]   mul_prod;

   // combinational helpers
   logic [STEP_BITS-1:0] steps_raw;
   logic [STEP_BITS-1:0] steps_mag;
   logic [DATA_W-1:0]    maxlim;
   logic [DVD_W-1:0]     alim;
   logic [COUNT_W-1:0]   split_len;
   logic [COUNT_W-1:0]   steps_nx;
   logic                 reached;
   logic [DATA_W:0]      dsum;
   logic [DATA_W-1:0]    newd;
   logic [DATA_W-1:0]    clamped;
   logic                 drive;
   logic [DATA_W-1:0]    alarm;
   logic                 div_waiting;
   logic                 commit_free;

   // deceleration length: at least one step, at most the whole move
   function automatic logic [COUNT_W-1:0] fit_dlen(input logic [DVD_W-1:0]   cand,
                                                   input logic [COUNT_W-1:0] n);
      logic [DVD_W-1:0] c;
      c = (cand == '0) ? DVD_W'(1) : cand;
      if (c > DVD_W'(n)) begin
         fit_dlen = n;
      end else begin
         fit_dlen = c[COUNT_W-1:0];
      end
   endfunction

   slrg_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // start magnitude and shared terms
   assign steps_raw = req_payload.move_steps;
   assign steps_mag = steps_raw[STEP_BITS-1] ? (~steps_raw + STEP_BITS'(1)) : steps_raw;
   assign maxlim    = (max_speed_ff == '0) ? DATA_W'(1) : max_speed_ff;
   assign alim      = (div_rsp.quotient == '0) ? DVD_W'(1) : div_rsp.quotient;
   assign split_len = (DVD_W'(n_ff) > alim) ? (n_ff - alim[COUNT_W-1:0]) : '0;
   assign mul_prod  = mul_a * mul_b;

   // tick arithmetic on the stored quotient
   assign steps_nx = (steps_done_ff == '1) ? steps_done_ff : steps_done_ff + COUNT_W'(1);
   assign reached  = {1'b0, steps_nx} >= decel_begin_ff;
   assign dsum     = {1'b0, cur_ff} + {1'b0, q_ff[DATA_W-1:0]};

   assign req_ready   = (state_ff == slrg_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign csr_ready   = 1'b1;

   // sequencer conditions watched by the checks
   assign div_waiting = state_ff inside {slrg_pkg::ST_WAIT_SPLIT, slrg_pkg::ST_WAIT_DECEL,
                                         slrg_pkg::ST_TICK_WAIT};
   assign commit_free = (state_ff == slrg_pkg::ST_COMMIT) && (!rsp_valid_ff || rsp_ready);

   // sequencer, next state and commit
   always_comb begin
      state_in        = state_ff;
      req_in          = req_ff;
      n_in            = n_ff;
      dlen_in         = dlen_ff;
      prod_in         = prod_ff;
      q_in            = q_ff;
      r_in            = r_ff;
      ri_work_in      = ri_work_ff;
      phase_in        = phase_ff;
      steps_done_in   = steps_done_ff;
      ramp_index_in   = ramp_index_ff;
      rem_in          = rem_ff;
      cur_in          = cur_ff;
      pending_in      = pending_ff;
      ramp_end_in     = ramp_end_ff;
      decel_length_in = decel_length_ff;
      decel_begin_in  = decel_begin_ff;
      dir_in          = dir_ff;
      run_in          = run_ff;
      timer_on_in     = timer_on_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_payload_in  = rsp_payload_ff;
      div_req         = '0;
      mul_a           = n_ff;
      mul_b           = decel_rate_ff;
      newd            = pending_ff;
      clamped         = pending_ff;
      drive           = 1'b0;
      alarm           = cur_ff;

      case (state_ff)
         slrg_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in = req_payload;
               if (req_payload.operation == slrg_pkg::OP_START) begin
                  n_in = {steps_mag, 1'b0};
                  if (steps_raw == '0) begin
                     state_in = slrg_pkg::ST_COMMIT;
                  end else begin
                     state_in = slrg_pkg::ST_MUL_SPLIT;
                  end
               end else begin
                  case (phase_ff)
                     slrg_pkg::PH_ACCEL: begin
                        ri_work_in = ramp_index_ff + WIDE_W'(1);
                        state_in   = slrg_pkg::ST_TICK_DIV;
                     end
                     slrg_pkg::PH_DECEL: begin
                        ri_work_in = (ramp_index_ff != '0) ? ramp_index_ff - WIDE_W'(1)
                                                           : ramp_index_ff;
                        state_in   = slrg_pkg::ST_TICK_DIV;
                     end
                     default: begin
                        state_in = slrg_pkg::ST_COMMIT;
                     end
                  endcase
               end
            end
         end

         // ramp split: n * decel / (accel + decel)
         slrg_pkg::ST_MUL_SPLIT: begin
            mul_a    = n_ff;
            mul_b    = decel_rate_ff;
            prod_in  = mul_prod;
            state_in = slrg_pkg::ST_DIV_SPLIT;
         end
         slrg_pkg::ST_DIV_SPLIT: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod_ff;
            div_req.divisor  = DVS_W'(accel_rate_ff) + DVS_W'(decel_rate_ff);
            state_in         = slrg_pkg::ST_WAIT_SPLIT;
         end
         slrg_pkg::ST_WAIT_SPLIT: begin
            if (div_rsp.done) begin
               if (alim <= DVD_W'(maxlim)) begin
                  dlen_in  = fit_dlen(DVD_W'(split_len), n_ff);
                  state_in = slrg_pkg::ST_COMMIT;
               end else begin
                  state_in = slrg_pkg::ST_MUL_DECEL;
               end
            end
         end

         // speed limited: maxlim * accel / decel
         slrg_pkg::ST_MUL_DECEL: begin
            mul_a    = COUNT_W'(maxlim);
            mul_b    = accel_rate_ff;
            prod_in  = mul_prod;
            state_in = slrg_pkg::ST_DIV_DECEL;
         end
         slrg_pkg::ST_DIV_DECEL: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod_ff;
            div_req.divisor  = DVS_W'(decel_rate_ff);
            state_in         = slrg_pkg::ST_WAIT_DECEL;
         end
         slrg_pkg::ST_WAIT_DECEL: begin
            if (div_rsp.done) begin
               dlen_in  = fit_dlen(div_rsp.quotient, n_ff);
               state_in = slrg_pkg::ST_COMMIT;
            end
         end

         // delay update: (2c + r) / (4n + 1)
         slrg_pkg::ST_TICK_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = DVD_W'({cur_ff, 1'b0}) + DVD_W'(rem_ff);
            div_req.divisor  = DVS_W'({ri_work_ff, 2'b01});
            state_in         = slrg_pkg::ST_TICK_WAIT;
         end
         slrg_pkg::ST_TICK_WAIT: begin
            if (div_rsp.done) begin
               q_in     = div_rsp.quotient;
               r_in     = div_rsp.remainder;
               state_in = slrg_pkg::ST_COMMIT;
            end
         end

         // write back ramp state and the result once the output register is free
         slrg_pkg::ST_COMMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (req_ff.operation == slrg_pkg::OP_START) begin
                  steps_done_in = '0;
                  if (req_ff.move_steps != '0) begin
                     dir_in          = !req_ff.move_steps[STEP_BITS-1];
                     decel_length_in = WIDE_W'(dlen_ff);
                     decel_begin_in  = WIDE_W'(n_ff - dlen_ff);
                     if (first_delay_ff <= min_delay_ff) begin
                        cur_in   = min_delay_ff;
                        phase_in = slrg_pkg::PH_RUN;
                     end else begin
                        cur_in   = first_delay_ff;
                        phase_in = slrg_pkg::PH_ACCEL;
                     end
                     ramp_index_in = '0;
                     timer_on_in   = 1'b1;
                     alarm         = slrg_pkg::ALARM_START;
                  end else begin
                     alarm = cur_ff;
                  end
               end else begin
                  case (phase_ff)
                     slrg_pkg::PH_ACCEL: begin
                        run_in        = 1'b1;
                        drive         = 1'b1;
                        steps_done_in = steps_nx;
                        ramp_index_in = ri_work_ff;
                        rem_in        = r_ff[WIDE_W-1:0];
                        newd = (DVD_W'(cur_ff) > q_ff) ? cur_ff - q_ff[DATA_W-1:0] : '0;
                        if (reached) begin
                           ramp_index_in = decel_length_ff;
                           phase_in      = slrg_pkg::PH_DECEL;
                        end else if (newd <= min_delay_ff) begin
                           ramp_end_in = newd;
                           newd        = min_delay_ff;
                           rem_in      = '0;
                           phase_in    = slrg_pkg::PH_RUN;
                        end
                     end
                     slrg_pkg::PH_RUN: begin
                        run_in        = 1'b1;
                        drive         = 1'b1;
                        steps_done_in = steps_nx;
                        newd          = min_delay_ff;
                        if (reached) begin
                           ramp_index_in = decel_length_ff;
                           newd          = ramp_end_ff;
                           phase_in      = slrg_pkg::PH_DECEL;
                        end
                     end
                     slrg_pkg::PH_DECEL: begin
                        run_in        = 1'b1;
                        drive         = 1'b1;
                        steps_done_in = steps_nx;
                        ramp_index_in = ri_work_ff;
                        rem_in        = r_ff[WIDE_W-1:0];
                        // saturate the slower delay at the top of the range
                        if ((q_ff[DVD_W-1:DATA_W] != '0) || dsum[DATA_W]) begin
                           newd = '1;
                        end else begin
                           newd = dsum[DATA_W-1:0];
                        end
                        if (ri_work_ff == '0) begin
                           phase_in = slrg_pkg::PH_STOP;
                        end
                     end
                     default: begin
                        steps_done_in = '0;
                        rem_in        = '0;
                        timer_on_in   = 1'b0;
                        run_in        = 1'b0;
                        newd          = pending_ff;
                     end
                  endcase
                  // floor test first, then ceiling
                  if (newd < delay_floor_ff) begin
                     clamped = delay_floor_ff;
                  end else if (newd > delay_ceiling_ff) begin
                     clamped = delay_ceiling_ff;
                  end else begin
                     clamped = newd;
                  end
                  pending_in = newd;
                  cur_in     = clamped;
                  alarm      = clamped;
               end
               rsp_valid_in                 = 1'b1;
               rsp_payload_in.step_level    = drive & req_ff.pin_level;
               rsp_payload_in.step_drive    = drive;
               rsp_payload_in.direction     = dir_in;
               rsp_payload_in.running       = run_in;
               rsp_payload_in.alarm_delay   = alarm;
               rsp_payload_in.timer_enabled = timer_on_in;
               state_in                     = slrg_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = slrg_pkg::ST_IDLE;
         end
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         first_delay_ff   <= DATA_W'(1000);
         max_speed_ff     <= DATA_W'(1);
         accel_rate_ff    <= DATA_W'(100);
         decel_rate_ff    <= DATA_W'(100);
         min_delay_ff     <= DATA_W'(20);
         delay_floor_ff   <= DATA_W'(100);
         delay_ceiling_ff <= DATA_W'(2000);
      end else if (csr_valid) begin
         case (csr_index)
            slrg_pkg::CSR_FIRST_DELAY:   first_delay_ff   <= csr_data;
            slrg_pkg::CSR_MAX_SPEED:     max_speed_ff     <= csr_data;
            slrg_pkg::CSR_ACCEL_RATE:    accel_rate_ff    <= csr_data;
            slrg_pkg::CSR_DECEL_RATE:    decel_rate_ff    <= csr_data;
            slrg_pkg::CSR_MIN_DELAY:     min_delay_ff     <= csr_data;
            slrg_pkg::CSR_DELAY_FLOOR:   delay_floor_ff   <= csr_data;
            slrg_pkg::CSR_DELAY_CEILING: delay_ceiling_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // control and ramp state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= slrg_pkg::ST_IDLE;
         phase_ff        <= slrg_pkg::PH_STOP;
         steps_done_ff   <= '0;
         ramp_index_ff   <= '0;
         rem_ff          <= '0;
         cur_ff          <= '0;
         pending_ff      <= '0;
         ramp_end_ff     <= '0;
         decel_length_ff <= '0;
         decel_begin_ff  <= '0;
         dir_ff          <= 1'b0;
         run_ff          <= 1'b0;
         timer_on_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         phase_ff        <= phase_in;
         steps_done_ff   <= steps_done_in;
         ramp_index_ff   <= ramp_index_in;
         rem_ff          <= rem_in;
         cur_ff          <= cur_in;
         pending_ff      <= pending_in;
         ramp_end_ff     <= ramp_end_in;
         decel_length_ff <= decel_length_in;
         decel_begin_ff  <= decel_begin_in;
         dir_ff          <= dir_in;
         run_ff          <= run_in;
         timer_on_ff     <= timer_on_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      n_ff           <= n_in;
      dlen_ff        <= dlen_in;
      prod_ff        <= prod_in;
      q_ff           <= q_in;
      r_ff           <= r_in;
      ri_work_ff     <= ri_work_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // the tick interrupt is only ever off in the stopped phase
   `SLRG_ASSERT(a_timer_off_stopped, clock, reset, !timer_on_ff |-> phase_ff == slrg_pkg::PH_STOP)

   // a driven step always reports a running motor
   `SLRG_ASSERT(a_drive_running, clock, reset, rsp_valid && rsp_payload.step_drive |-> rsp_payload.running)

   // divider results only land while the sequencer waits for one
   `SLRG_ASSERT(a_div_done_waiting, clock, reset, div_rsp.done |-> div_waiting)

   // a commit with a free output slot presents a result next cycle
   `SLRG_ASSERT_NEXT(a_commit_result, clock, reset, commit_free, rsp_valid_ff && req_ready)

endmodule
